@@ rtl/access_rule_hash_table_core_macros.svh @@
// assertion macros for the access rule hash table
`ifndef ACCESS_RULE_HASH_TABLE_CORE_MACROS_SVH
`define ACCESS_RULE_HASH_TABLE_CORE_MACROS_SVH

// concurrent assertion on clk_i, off while in reset
`define ARHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

@@ rtl/arht_pkg.sv @@
// package: sizes, codes and types of the access rule hash table
`default_nettype none
package arht_pkg;
  localparam int unsigned BUCKETS = 1024;
  localparam int unsigned WAYS = 4;
  localparam int unsigned IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned FILL_W = $clog2(WAYS + 1);
  localparam int unsigned TGT_SHIFT = 2;
  localparam int unsigned SRC_SHIFT = 9;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned CNT_W = 13;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic REQ_SEARCH = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic [47:0] key;
    logic [7:0]  kind;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] vc;
  } entry_t;

  typedef struct packed {
    logic [FILL_W-1:0]      fill;
    entry_t [WAYS-1:0]      ways;
  } row_t;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] bucket;
    entry_t           ent;
  } req_t;
endpackage
`default_nettype wire

@@ rtl/arht_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module arht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

@@ rtl/arht_front.sv @@
// front: accepts items, hashes the key and queues them for the back
`default_nettype none
module arht_front import arht_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        req_type_i,
  input  wire logic [15:0] source_type_i,
  input  wire logic [15:0] target_type_i,
  input  wire logic [15:0] target_class_i,
  input  wire logic [7:0]  kind_mask_i,
  input  wire logic [31:0] value_a_i,
  input  wire logic [31:0] value_b_i,
  input  wire logic [31:0] value_c_i,
  input  wire logic        clearing_i,
  input  wire logic        pop_i,
  output logic             busy_o,
  output logic             valid_o,
  output req_t             head_o
);
  localparam int unsigned PTR_W = $clog2(QDEPTH);

  req_t             q_q [QDEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             push;
  logic [31:0]      hash;
  req_t             item;

  assign hash = 32'(target_class_i) + (32'(target_type_i) << TGT_SHIFT)
              + (32'(source_type_i) << SRC_SHIFT);

  always_comb begin
    item.req_type = req_type_i;
    item.bucket   = IDX_W'(hash & 32'(BUCKETS - 1));
    item.ent.key  = {source_type_i, target_type_i, target_class_i};
    item.ent.kind = kind_mask_i;
    item.ent.va   = value_a_i;
    item.ent.vb   = value_b_i;
    item.ent.vc   = value_c_i;
  end

  assign busy_o  = clearing_i || (cnt_q == (PTR_W+1)'(QDEPTH));
  assign push    = start && !busy_o;
  assign valid_o = (cnt_q != '0);
  assign head_o  = q_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= PTR_W'((32'(wptr_q) + 1) % QDEPTH);
      end
      if (pop_i) begin
        rptr_q <= PTR_W'((32'(rptr_q) + 1) % QDEPTH);
      end
      cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

@@ rtl/arht_back.sv @@
// back: reads a bucket row, searches or inserts, writes back and reports
`default_nettype none
module arht_back import arht_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire req_t              head_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [7:0]             found_kind_o,
  output logic [31:0]            found_a_o,
  output logic [31:0]            found_b_o,
  output logic [31:0]            found_c_o,
  output logic [CNT_W-1:0]       entry_count_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;

  logic [1:0]       state_q, state_d;
  req_t             cur_q;
  logic             clr_q;
  logic [IDX_W-1:0] clr_idx_q;
  logic [CNT_W-1:0] total_q;

  logic             we;
  logic [IDX_W-1:0] addr;
  row_t             wrow, rrow;
  logic [$bits(row_t)-1:0] rdata;

  logic [FILL_W-1:0] fill, pos;
  logic              dup, stop;
  entry_t            sel, ins;
  row_t              nrow;
  logic [1:0]        status;
  logic              do_write;

  arht_ram #(.WIDTH($bits(row_t)), .DEPTH(BUCKETS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wrow),
    .rdata_o(rdata)
  );

  assign rrow       = row_t'(rdata);
  assign clearing_o = clr_q;
  assign pop_o      = !clr_q && (state_q == S_IDLE) && valid_i;

  always_comb begin
    fill = (rrow.fill > FILL_W'(WAYS)) ? FILL_W'(WAYS) : rrow.fill;
    ins  = cur_q.ent;
    pos  = fill;
    dup  = 1'b0;
    stop = 1'b0;
    sel  = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!stop && (FILL_W'(i) < fill)) begin
        if ((rrow.ways[i].key == ins.key) && ((rrow.ways[i].kind & ins.kind) != '0)) begin
          dup  = 1'b1;
          pos  = FILL_W'(i);
          stop = 1'b1;
        end else if (ins.key < rrow.ways[i].key) begin
          pos  = FILL_W'(i);
          stop = 1'b1;
        end
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (FILL_W'(i) == pos) begin
        sel = rrow.ways[i];
      end
    end
    nrow = rrow;
    nrow.fill = fill + FILL_W'(1);
    nrow.ways[0] = (pos == '0) ? ins : rrow.ways[0];
    for (int i = 1; i < WAYS; i++) begin
      if (FILL_W'(i) == pos) begin
        nrow.ways[i] = ins;
      end else if (FILL_W'(i) > pos) begin
        nrow.ways[i] = rrow.ways[i-1];
      end
    end
    do_write = 1'b0;
    if (cur_q.req_type == REQ_SEARCH) begin
      status = dup ? ST_OK : ST_MISS;
    end else if (dup) begin
      status = ST_DUP;
    end else if (fill >= FILL_W'(WAYS)) begin
      status = ST_FULL;
    end else begin
      status   = ST_OK;
      do_write = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    addr    = head_i.bucket;
    wrow    = nrow;
    if (clr_q) begin
      we   = 1'b1;
      addr = clr_idx_q;
      wrow = '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            state_d = S_READ;
          end
        end
        S_READ: begin
          addr    = cur_q.bucket;
          we      = (state_q == S_READ) && do_write;
          state_d = S_IDLE;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      clr_q         <= 1'b1;
      clr_idx_q     <= '0;
      total_q       <= '0;
      done_o        <= 1'b0;
      status_o      <= ST_OK;
      found_kind_o  <= '0;
      found_a_o     <= '0;
      found_b_o     <= '0;
      found_c_o     <= '0;
      entry_count_o <= '0;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(BUCKETS - 1)) begin
          clr_q <= 1'b0;
        end
      end else if (state_q == S_READ) begin
        done_o   <= 1'b1;
        status_o <= status;
        if ((cur_q.req_type == REQ_SEARCH) && dup) begin
          found_kind_o <= sel.kind;
          found_a_o    <= sel.va;
          found_b_o    <= sel.vb;
          found_c_o    <= sel.vc;
        end else begin
          found_kind_o <= '0;
          found_a_o    <= '0;
          found_b_o    <= '0;
          found_c_o    <= '0;
        end
        total_q       <= total_q + CNT_W'(do_write);
        entry_count_o <= total_q + CNT_W'(do_write);
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/access_rule_hash_table_core.sv @@
// top level of the access rule hash table
// each accepted item is queued, its row read, and its result registered with done_o
// the back handles one item at a time: it reads then writes one bucket row
// on the single-port row memory; a 2-item queue sits between front and back
// reset: a clearing pass zeroes all BUCKETS rows (1024), busy stays high
// results cannot be stalled: done_o marks each one for exactly one cycle
`default_nettype none
module access_rule_hash_table_core import arht_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type_i,
  input  wire logic [15:0] source_type_i,
  input  wire logic [15:0] target_type_i,
  input  wire logic [15:0] target_class_i,
  input  wire logic [7:0]  kind_mask_i,
  input  wire logic [31:0] value_a_i,
  input  wire logic [31:0] value_b_i,
  input  wire logic [31:0] value_c_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [7:0]       found_kind_o,
  output logic [31:0]      found_a_o,
  output logic [31:0]      found_b_o,
  output logic [31:0]      found_c_o,
  output logic [12:0]      entry_count_o
);
  logic clearing, pop, valid;
  req_t head;

  arht_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_type_i    (req_type_i),
    .source_type_i (source_type_i),
    .target_type_i (target_type_i),
    .target_class_i(target_class_i),
    .kind_mask_i   (kind_mask_i),
    .value_a_i     (value_a_i),
    .value_b_i     (value_b_i),
    .value_c_i     (value_c_i),
    .clearing_i    (clearing),
    .pop_i         (pop),
    .busy_o        (busy),
    .valid_o       (valid),
    .head_o        (head)
  );

  arht_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid),
    .head_i       (head),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_kind_o (found_kind_o),
    .found_a_o    (found_a_o),
    .found_b_o    (found_b_o),
    .found_c_o    (found_c_o),
    .entry_count_o(entry_count_o)
  );
endmodule
`default_nettype wire

@@ rtl/arht_checker.sv @@
// port-level checker for the access rule hash table, bound to the top level
`default_nettype none
`include "access_rule_hash_table_core_macros.svh"
module arht_checker import arht_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic [7:0]  found_kind_o,
  input wire logic [31:0] found_a_o,
  input wire logic [12:0] entry_count_o
);
  `ARHT_ASSERT(a_no_back_to_back, done_o |=> !done_o, "done strobes in adjacent cycles")
  `ARHT_ASSERT(a_miss_zero, (done_o && status_o == ST_MISS) |-> (found_kind_o == '0 && found_a_o == '0), "miss with data")
  `ARHT_ASSERT(a_dup_zero, (done_o && (status_o == ST_DUP || status_o == ST_FULL)) |-> (found_kind_o == '0), "reject with data")
  `ARHT_ASSERT(a_count_stable, !done_o |-> $stable(entry_count_o), "count moved without an item")
endmodule

bind access_rule_hash_table_core arht_checker u_arht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .done_o       (done_o),
  .status_o     (status_o),
  .found_kind_o (found_kind_o),
  .found_a_o    (found_a_o),
  .entry_count_o(entry_count_o)
);
`default_nettype wire
